// ===== rtl/msl_pkg.sv =====
// Shared types, symbol codes and the Morse code table for the symbol decoder.
// No dependencies; used by every module of the decoder.
`default_nettype none

package msl_pkg;

    // Symbol kind codes carried by the input item.
    localparam logic [1:0] KIND_DOT  = 2'd0;
    localparam logic [1:0] KIND_DASH = 2'd1;
    localparam logic [1:0] KIND_GAP  = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    // Widths of the lookup interface; a code never exceeds LOOKUP_BITS symbols.
    localparam int LOOKUP_BITS  = 16;
    localparam int LOOKUP_LEN_W = 5;
    localparam int LIMIT_W      = 5;
    localparam int LETTER_W     = 7;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET    = 5'd20;
    localparam logic [LETTER_W-1:0] LETTER_SPACE   = 7'h20;
    localparam logic [LETTER_W-1:0] LETTER_UNKNOWN = 7'h3F;
    localparam logic [LETTER_W-1:0] LETTER_NONE    = 7'h00;

    // One table entry: symbol count, dash mask (bit 0 is the first symbol), character.
    typedef struct packed {
        logic [2:0]          len;
        logic [5:0]          bits;
        logic [LETTER_W-1:0] ch;
    } t_code_entry;

    // One result item as it travels to the output register.
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                letter_valid;
        logic                message_end;
    } t_result;

    localparam int CODE_TABLE_SIZE = 40;

    localparam t_code_entry CODE_TABLE [CODE_TABLE_SIZE] = '{
        '{3'd2, 6'd2,  7'h41}, '{3'd4, 6'd1,  7'h42}, '{3'd4, 6'd5,  7'h43},
        '{3'd3, 6'd1,  7'h44}, '{3'd1, 6'd0,  7'h45}, '{3'd4, 6'd4,  7'h46},
        '{3'd3, 6'd3,  7'h47}, '{3'd4, 6'd0,  7'h48}, '{3'd2, 6'd0,  7'h49},
        '{3'd4, 6'd14, 7'h4A}, '{3'd3, 6'd5,  7'h4B}, '{3'd4, 6'd2,  7'h4C},
        '{3'd2, 6'd3,  7'h4D}, '{3'd2, 6'd1,  7'h4E}, '{3'd3, 6'd7,  7'h4F},
        '{3'd4, 6'd6,  7'h50}, '{3'd4, 6'd11, 7'h51}, '{3'd3, 6'd2,  7'h52},
        '{3'd3, 6'd0,  7'h53}, '{3'd1, 6'd1,  7'h54}, '{3'd3, 6'd4,  7'h55},
        '{3'd4, 6'd8,  7'h56}, '{3'd3, 6'd6,  7'h57}, '{3'd4, 6'd9,  7'h58},
        '{3'd4, 6'd13, 7'h59}, '{3'd4, 6'd3,  7'h5A}, '{3'd5, 6'd31, 7'h30},
        '{3'd5, 6'd30, 7'h31}, '{3'd5, 6'd28, 7'h32}, '{3'd5, 6'd24, 7'h33},
        '{3'd5, 6'd16, 7'h34}, '{3'd5, 6'd0,  7'h35}, '{3'd5, 6'd1,  7'h36},
        '{3'd5, 6'd3,  7'h37}, '{3'd5, 6'd7,  7'h38}, '{3'd5, 6'd15, 7'h39},
        '{3'd6, 6'd42, 7'h2E}, '{3'd6, 6'd51, 7'h2C}, '{3'd6, 6'd12, 7'h3F},
        '{3'd6, 6'd53, 7'h21}
    };

    // Match a gathered code against the table. Empty code is a space,
    // anything without a match is a question mark.
    function automatic logic [LETTER_W-1:0] lookup_letter(
        input logic [LOOKUP_LEN_W-1:0] len,
        input logic [LOOKUP_BITS-1:0]  bits
    );
        logic [LETTER_W-1:0] ch;
        ch = (len == '0) ? LETTER_SPACE : LETTER_UNKNOWN;
        for (int i = 0; i < CODE_TABLE_SIZE; i++) begin
            if (len == LOOKUP_LEN_W'(CODE_TABLE[i].len) &&
                bits == LOOKUP_BITS'(CODE_TABLE[i].bits)) begin
                ch = CODE_TABLE[i].ch;
            end
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/msl_code_unit.sv =====
// Code gatherer: collects dots and dashes and decodes the current code.
// Depends on msl_pkg for the symbol codes and the table lookup.
`default_nettype none

module msl_code_unit #(
    parameter int MAX_CODE_SYMBOLS = 9
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [1:0]                    i_kind,
    output logic [msl_pkg::LETTER_W-1:0]       o_char,
    output logic                               o_empty
);

    localparam int CodeLenW = $clog2(MAX_CODE_SYMBOLS + 1);

    logic [MAX_CODE_SYMBOLS-1:0] r_code_bits, n_code_bits;
    logic [CodeLenW-1:0]         r_code_len,  n_code_len;

    // Append a symbol while room is left; gap and message end clear the code.
    always_comb begin
        n_code_bits = r_code_bits;
        n_code_len  = r_code_len;
        if (i_step) begin
            if (i_kind == msl_pkg::KIND_DOT || i_kind == msl_pkg::KIND_DASH) begin
                if (r_code_len < CodeLenW'(MAX_CODE_SYMBOLS)) begin
                    for (int i = 0; i < MAX_CODE_SYMBOLS; i++) begin
                        if (r_code_len == CodeLenW'(i) && i_kind == msl_pkg::KIND_DASH) begin
                            n_code_bits[i] = 1'b1;
                        end
                    end
                    n_code_len = r_code_len + CodeLenW'(1);
                end
            end else begin
                n_code_bits = '0;
                n_code_len  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits <= '0;
            r_code_len  <= '0;
        end else begin
            r_code_bits <= n_code_bits;
            r_code_len  <= n_code_len;
        end
    end

    // Table match on the code as it stands.
    assign o_char  = msl_pkg::lookup_letter(msl_pkg::LOOKUP_LEN_W'(r_code_len),
                                            msl_pkg::LOOKUP_BITS'(r_code_bits));
    assign o_empty = (r_code_len == '0);

endmodule

`default_nettype wire

// ===== rtl/msl_out_reg.sv =====
// Result register with valid/ready handshake toward the consumer.
// Depends on msl_pkg for the result item type.
`default_nettype none

module msl_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire msl_pkg::t_result i_result,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output msl_pkg::t_result      o_result
);

    logic             r_valid;
    msl_pkg::t_result r_result;

    // Valid flag: set on load, cleared when the consumer takes the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/morse_symbol_to_letter_decoder.sv =====
// Top level of the Morse symbol decoder; uses msl_pkg, msl_code_unit and msl_out_reg.
// Each symbol is first loaded into the input register, and its result item is then loaded
// into the result register once that register can take it.
// Throughput: one symbol per cycle; the input register moves on whenever its symbol
// makes no result or the result register is free or being emptied. Synchronous active-low
// reset clears the code, the letter count and both valid flags, and sets the limit to 20.
`default_nettype none

module morse_symbol_to_letter_decoder #(
    parameter int MAX_CODE_SYMBOLS = 9
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [msl_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [1:0]                  i_symbol_kind,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [msl_pkg::LETTER_W-1:0]     o_letter,
    output logic                             o_letter_valid,
    output logic                             o_message_end
);

    logic                        r_in_valid;
    logic [1:0]                  r_in_kind;
    logic [msl_pkg::LIMIT_W-1:0] r_limit;
    logic [msl_pkg::LIMIT_W-1:0] r_emitted, n_emitted;

    logic [msl_pkg::LETTER_W-1:0] code_char;
    logic                         code_empty;
    logic                         under_limit;
    logic                         makes_result;
    logic                         advance;
    logic                         out_valid;
    msl_pkg::t_result             result, out_result;

    // Letter limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= msl_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Input register: holds one symbol until it is processed.
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_kind <= i_symbol_kind;
        end
    end

    msl_code_unit #(
        .MAX_CODE_SYMBOLS(MAX_CODE_SYMBOLS)
    ) u_code (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (advance),
        .i_kind (r_in_kind),
        .o_char (code_char),
        .o_empty(code_empty)
    );

    // Decide the result item of the held symbol.
    assign under_limit  = (r_emitted < r_limit);
    assign makes_result = (r_in_kind == msl_pkg::KIND_END) ||
                          (r_in_kind == msl_pkg::KIND_GAP && under_limit);
    assign advance      = r_in_valid && (!makes_result || !out_valid || i_ready);

    always_comb begin
        result.letter       = msl_pkg::LETTER_NONE;
        result.letter_valid = 1'b0;
        result.message_end  = 1'b0;
        if (r_in_kind == msl_pkg::KIND_GAP) begin
            result.letter       = code_char;
            result.letter_valid = 1'b1;
        end else if (r_in_kind == msl_pkg::KIND_END) begin
            result.message_end = 1'b1;
            if (!code_empty && under_limit) begin
                result.letter       = code_char;
                result.letter_valid = 1'b1;
            end
        end
    end

    // Letters emitted in the current message; message end starts over.
    always_comb begin
        n_emitted = r_emitted;
        if (advance) begin
            if (r_in_kind == msl_pkg::KIND_END) begin
                n_emitted = '0;
            end else if (r_in_kind == msl_pkg::KIND_GAP && under_limit) begin
                n_emitted = r_emitted + msl_pkg::LIMIT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emitted <= '0;
        end else begin
            r_emitted <= n_emitted;
        end
    end

    msl_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && makes_result),
        .i_result(result),
        .i_ready (i_ready),
        .o_valid (out_valid),
        .o_result(out_result)
    );

    assign o_valid        = out_valid;
    assign o_letter       = out_result.letter;
    assign o_letter_valid = out_result.letter_valid;
    assign o_message_end  = out_result.message_end;

endmodule

`default_nettype wire

// ===== rtl/msl_checker.sv =====
// Port-level checks on the decoder's result channel and reset.
// Bound to morse_symbol_to_letter_decoder; no package dependency.
`default_nettype none

module msl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [6:0] o_letter,
    input wire logic       o_letter_valid,
    input wire logic       o_message_end
);

    // A stalled result item holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_letter) &&
        $stable(o_letter_valid) && $stable(o_message_end))
        else $error("result item changed while stalled");

    // A result item that does not close the message always carries a letter.
    a_gap_has_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_message_end |-> o_letter_valid)
        else $error("letter gap result without a letter");

    // A result item without a letter shows a zero letter field.
    a_no_letter_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_letter_valid |-> o_letter == 7'd0)
        else $error("letter field not zero without a letter");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result still valid after reset");

endmodule

bind morse_symbol_to_letter_decoder msl_checker u_msl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_letter      (o_letter),
    .o_letter_valid(o_letter_valid),
    .o_message_end (o_message_end)
);

`default_nettype wire
